@@ rtl/lfbs_pkg.sv @@
// ----------------------------------------------------------------------------
// lfbs_pkg: shared types and constants for the LED fade/blink sequencer
// Field widths, register indexes, item kinds and the serial multiply helper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lfbs_pkg;

   localparam int CHAN_W     = 8;                 // one colour channel
   localparam int NUM_CHAN   = 3;                 // red, green, blue
   localparam int COLOR_W    = CHAN_W * NUM_CHAN;
   localparam int LEVEL_W    = 8;
   localparam int SQ_W       = 2 * LEVEL_W;       // level * level
   localparam int PROD_W     = SQ_W + CHAN_W;     // colour * level * level
   localparam int QUOT_W     = PROD_W - CHAN_W + 1;
   localparam int REM_W      = PROD_W + 2;
   localparam int DIGIT_W    = 2;                 // multiplier bits per cycle
   localparam int MUL_STEPS  = CHAN_W / DIGIT_W;
   localparam int STEP_CNT_W = $clog2(MUL_STEPS);
   localparam int KIND_W     = 2;
   localparam int HOLD_W     = 8;
   localparam int TICKS_W    = 8;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = COLOR_W;

   localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_NOTIFY = 2'd1;
   localparam logic [KIND_W-1:0] KIND_WEAK   = 2'd2;

   localparam logic [HOLD_W-1:0]  HOLD_DEFAULT    = 8'd3;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX_RESET = 8'd10;
   localparam logic [LEVEL_W-1:0] LEVEL_MIN_RESET = 8'd0;
   localparam logic [LEVEL_W-1:0] STEP_RESET      = 8'd2;

   // remainder bound of the divide-by-255 correction
   localparam logic [REM_W-1:0] DIV_CONST = 26'd255;
   localparam logic [REM_W-1:0] REM_LIMIT = 26'd510;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_LEVEL_MAX       = 3'd0,
      CSR_LEVEL_MIN       = 3'd1,
      CSR_LEVEL_STEP      = 3'd2,
      CSR_BLINK_ENABLE    = 3'd3,
      CSR_BLINK_COLOR     = 3'd4,
      CSR_BLINK_ON_TICKS  = 3'd5,
      CSR_BLINK_OFF_TICKS = 3'd6
   } csr_index_type;

   // multiplicand times one multiplier digit, by shifted adds
   function automatic logic [PROD_W-1:0] mul_digit(input logic [PROD_W-1:0]  x,
                                                    input logic [DIGIT_W-1:0] d);
      logic [PROD_W-1:0] acc;
      acc = '0;
      for (int i = 0; i < DIGIT_W; i++) begin
         if (d[i]) begin
            acc = acc + (x << i);
         end
      end
      return acc;
   endfunction

endpackage

@@ rtl/led_fade_blink_sequencer_unit.sv @@
// ----------------------------------------------------------------------------
// led_fade_blink_sequencer_unit: notification fade and blink colour sequencer
// Notify beats update the fade state and give no result. A tick beat outside a
// fade goes to ST_EMIT; during a fade it squares the level (ST_SQUARE),
// multiplies each colour by the square (ST_MULT), 2 bits a cycle, and divides by
// 255 (ST_DIV, ST_FIX). Requests stall until it is emitted. Synchronous reset
// restores register defaults, stops any fade and drops a pending result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module led_fade_blink_sequencer_unit (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [lfbs_pkg::KIND_W-1:0]         req_kind,
   input  logic [lfbs_pkg::CHAN_W-1:0]         req_red,
   input  logic [lfbs_pkg::CHAN_W-1:0]         req_green,
   input  logic [lfbs_pkg::CHAN_W-1:0]         req_blue,
   input  logic [lfbs_pkg::HOLD_W-1:0]         req_hold_request,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [lfbs_pkg::CHAN_W-1:0]         rsp_out_red,
   output logic [lfbs_pkg::CHAN_W-1:0]         rsp_out_green,
   output logic [lfbs_pkg::CHAN_W-1:0]         rsp_out_blue,
   output logic                                rsp_fading,
   // register write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lfbs_pkg::CSR_ADDR_W-1:0]     csr_index,
   input  logic [lfbs_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_MULT,
      ST_DIV,
      ST_FIX,
      ST_EMIT
   } state_type;

   localparam int CW = lfbs_pkg::CHAN_W;
   localparam int NC = lfbs_pkg::NUM_CHAN;
   localparam int LW = lfbs_pkg::LEVEL_W;
   localparam int TW = lfbs_pkg::TICKS_W;
   localparam int HW = lfbs_pkg::HOLD_W;

   // configuration
   logic [LW-1:0]                    level_max_ff, level_max_in;
   logic [LW-1:0]                    level_min_ff, level_min_in;
   logic [LW-1:0]                    level_step_ff, level_step_in;
   logic                             blink_enable_ff, blink_enable_in;
   logic [lfbs_pkg::COLOR_W-1:0]     blink_color_ff, blink_color_in;
   logic [TW-1:0]                    blink_on_ticks_ff, blink_on_ticks_in;
   logic [TW-1:0]                    blink_off_ticks_ff, blink_off_ticks_in;

   // sequencer state
   logic                             fade_active_ff, fade_active_in;
   logic                             rising_ff, rising_in;
   logic [LW-1:0]                    level_ff, level_in;
   logic [HW-1:0]                    pause_left_ff, pause_left_in;
   logic [HW-1:0]                    hold_ticks_ff, hold_ticks_in;
   logic [lfbs_pkg::COLOR_W-1:0]     fade_color_ff, fade_color_in;
   logic [TW-1:0]                    blink_on_left_ff, blink_on_left_in;
   logic [TW-1:0]                    blink_off_left_ff, blink_off_left_in;
   logic                             blink_restart_ff, blink_restart_in;

   // serial datapath
   state_type                        state_ff, state_in;
   logic [lfbs_pkg::STEP_CNT_W-1:0]  step_cnt_ff, step_cnt_in;
   logic [LW-1:0]                    lvl_mplier_ff, lvl_mplier_in;
   logic [lfbs_pkg::SQ_W-1:0]        sq_mcand_ff, sq_mcand_in;
   logic [lfbs_pkg::SQ_W-1:0]        sq_ff, sq_in;
   logic [lfbs_pkg::PROD_W-1:0]      prod_mcand_ff, prod_mcand_in;
   logic [CW-1:0]                    chan_mplier_ff [NC];
   logic [CW-1:0]                    chan_mplier_in [NC];
   logic [lfbs_pkg::PROD_W-1:0]      prod_ff [NC];
   logic [lfbs_pkg::PROD_W-1:0]      prod_in [NC];
   logic [lfbs_pkg::QUOT_W-1:0]      quot_ff [NC];
   logic [lfbs_pkg::QUOT_W-1:0]      quot_in [NC];
   logic [CW-1:0]                    res_chan_ff [NC];
   logic [CW-1:0]                    res_chan_in [NC];
   logic                             res_fading_ff, res_fading_in;

   // output register
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]                    rsp_chan_ff [NC];
   logic [CW-1:0]                    rsp_chan_in [NC];
   logic                             rsp_fading_ff, rsp_fading_in;

   // combinational helpers
   logic                             req_acc;
   logic [LW:0]                      up_sum;
   logic [LW:0]                      floor_sum;
   logic [TW-1:0]                    blink_on_cur;
   logic [TW-1:0]                    blink_off_cur;
   logic [lfbs_pkg::PROD_W:0]        div_sum [NC];
   logic [lfbs_pkg::REM_W-1:0]       div_rem [NC];
   logic                             rem_ok;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_red   = rsp_chan_ff[0];
   assign rsp_out_green = rsp_chan_ff[1];
   assign rsp_out_blue  = rsp_chan_ff[2];
   assign rsp_fading    = rsp_fading_ff;

   // rising stops once level + step reaches the ceiling (signed compare in effect)
   assign up_sum    = {1'b0, level_ff} + {1'b0, level_step_ff};
   assign floor_sum = {1'b0, level_min_ff} + {1'b0, level_step_ff};

   assign blink_on_cur  = blink_restart_ff ? blink_on_ticks_ff : blink_on_left_ff;
   assign blink_off_cur = blink_restart_ff ? '0 : blink_off_left_ff;

   // divide by 255: estimate p*(1/256 + 1/2^16 + 1/2^24), short by at most one
   always_comb begin
      rem_ok = 1'b1;
      for (int i = 0; i < NC; i++) begin
         div_sum[i] = {1'b0, prod_ff[i]}
                    + {9'd0, prod_ff[i][lfbs_pkg::PROD_W-1:8]}
                    + {17'd0, prod_ff[i][lfbs_pkg::PROD_W-1:16]};
         div_rem[i] = lfbs_pkg::REM_W'(prod_ff[i]) + lfbs_pkg::REM_W'(quot_ff[i])
                    - (lfbs_pkg::REM_W'(quot_ff[i]) << 8);
         if (div_rem[i] >= lfbs_pkg::REM_LIMIT) begin
            rem_ok = 1'b0;
         end
      end
   end

   always_comb begin
      level_max_in       = level_max_ff;
      level_min_in       = level_min_ff;
      level_step_in      = level_step_ff;
      blink_enable_in    = blink_enable_ff;
      blink_color_in     = blink_color_ff;
      blink_on_ticks_in  = blink_on_ticks_ff;
      blink_off_ticks_in = blink_off_ticks_ff;

      fade_active_in     = fade_active_ff;
      rising_in          = rising_ff;
      level_in           = level_ff;
      pause_left_in      = pause_left_ff;
      hold_ticks_in      = hold_ticks_ff;
      fade_color_in      = fade_color_ff;
      blink_on_left_in   = blink_on_left_ff;
      blink_off_left_in  = blink_off_left_ff;
      blink_restart_in   = blink_restart_ff;

      state_in           = state_ff;
      step_cnt_in        = step_cnt_ff;
      lvl_mplier_in      = lvl_mplier_ff;
      sq_mcand_in        = sq_mcand_ff;
      sq_in              = sq_ff;
      prod_mcand_in      = prod_mcand_ff;
      chan_mplier_in     = chan_mplier_ff;
      prod_in            = prod_ff;
      quot_in            = quot_ff;
      res_chan_in        = res_chan_ff;
      res_fading_in      = res_fading_ff;

      rsp_valid_in       = rsp_valid_ff;
      rsp_chan_in        = rsp_chan_ff;
      rsp_fading_in      = rsp_fading_ff;

      if (csr_valid && csr_ready) begin
         unique case (lfbs_pkg::csr_index_type'(csr_index))
            lfbs_pkg::CSR_LEVEL_MAX:       level_max_in       = csr_wdata[LW-1:0];
            lfbs_pkg::CSR_LEVEL_MIN:       level_min_in       = csr_wdata[LW-1:0];
            lfbs_pkg::CSR_LEVEL_STEP:      level_step_in      = csr_wdata[LW-1:0];
            lfbs_pkg::CSR_BLINK_ENABLE:    blink_enable_in    = csr_wdata[0];
            lfbs_pkg::CSR_BLINK_COLOR:     blink_color_in     = csr_wdata;
            lfbs_pkg::CSR_BLINK_ON_TICKS:  blink_on_ticks_in  = csr_wdata[TW-1:0];
            lfbs_pkg::CSR_BLINK_OFF_TICKS: blink_off_ticks_in = csr_wdata[TW-1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_kind == lfbs_pkg::KIND_NOTIFY ||
                   (req_kind == lfbs_pkg::KIND_WEAK && !fade_active_ff)) begin
                  fade_color_in  = {req_red, req_green, req_blue};
                  rising_in      = 1'b1;
                  fade_active_in = 1'b1;
                  level_in       = level_min_ff;
                  pause_left_in  = '0;
                  hold_ticks_in  = (req_hold_request == '0) ? lfbs_pkg::HOLD_DEFAULT
                                                            : req_hold_request;
               end else if (req_kind == lfbs_pkg::KIND_TICK) begin
                  if (fade_active_ff) begin
                     if (pause_left_ff == '0) begin
                        if (rising_ff) begin
                           if (up_sum >= {1'b0, level_max_ff}) begin
                              rising_in     = 1'b0;
                              pause_left_in = hold_ticks_ff;
                           end else begin
                              level_in = up_sum[LW-1:0];
                           end
                        end else begin
                           if ({1'b0, level_ff} <= floor_sum) begin
                              fade_active_in = 1'b0;
                              level_in       = '0;
                           end else begin
                              level_in = level_ff - level_step_ff;
                           end
                        end
                     end else begin
                        pause_left_in = pause_left_ff - 1'b1;
                     end
                     lvl_mplier_in = level_in;
                     sq_mcand_in   = lfbs_pkg::SQ_W'(level_in);
                     sq_in         = '0;
                     step_cnt_in   = '0;
                     state_in      = ST_SQUARE;
                  end else begin
                     for (int i = 0; i < NC; i++) begin
                        res_chan_in[i] = '0;
                     end
                     res_fading_in = 1'b0;
                     if (blink_enable_ff) begin
                        blink_restart_in = 1'b0;
                        if (blink_on_cur != '0) begin
                           blink_on_left_in  = blink_on_cur - 1'b1;
                           blink_off_left_in = blink_off_cur;
                           res_chan_in[0]    = blink_color_ff[23:16];
                           res_chan_in[1]    = blink_color_ff[15:8];
                           res_chan_in[2]    = blink_color_ff[7:0];
                        end else if (blink_off_cur != '0) begin
                           blink_on_left_in  = blink_on_cur;
                           blink_off_left_in = blink_off_cur - 1'b1;
                        end else begin
                           // period over: reload both counts, this tick is dark
                           blink_on_left_in  = blink_on_ticks_ff;
                           blink_off_left_in = blink_off_ticks_ff;
                        end
                     end else begin
                        blink_restart_in  = 1'b1;
                        blink_off_left_in = '0;
                     end
                     state_in = ST_EMIT;
                  end
               end
            end
         end

         ST_SQUARE: begin
            sq_in = sq_ff + lfbs_pkg::SQ_W'(lfbs_pkg::mul_digit(
                       lfbs_pkg::PROD_W'(sq_mcand_ff),
                       lvl_mplier_ff[lfbs_pkg::DIGIT_W-1:0]));
            sq_mcand_in   = sq_mcand_ff << lfbs_pkg::DIGIT_W;
            lvl_mplier_in = lvl_mplier_ff >> lfbs_pkg::DIGIT_W;
            if (step_cnt_ff == lfbs_pkg::STEP_CNT_W'(lfbs_pkg::MUL_STEPS - 1)) begin
               step_cnt_in       = '0;
               prod_mcand_in     = lfbs_pkg::PROD_W'(sq_in);
               chan_mplier_in[0] = fade_color_ff[23:16];
               chan_mplier_in[1] = fade_color_ff[15:8];
               chan_mplier_in[2] = fade_color_ff[7:0];
               for (int i = 0; i < NC; i++) begin
                  prod_in[i] = '0;
               end
               state_in = ST_MULT;
            end else begin
               step_cnt_in = step_cnt_ff + 1'b1;
            end
         end

         ST_MULT: begin
            for (int i = 0; i < NC; i++) begin
               prod_in[i] = prod_ff[i] + lfbs_pkg::mul_digit(
                               prod_mcand_ff, chan_mplier_ff[i][lfbs_pkg::DIGIT_W-1:0]);
               chan_mplier_in[i] = chan_mplier_ff[i] >> lfbs_pkg::DIGIT_W;
            end
            prod_mcand_in = prod_mcand_ff << lfbs_pkg::DIGIT_W;
            if (step_cnt_ff == lfbs_pkg::STEP_CNT_W'(lfbs_pkg::MUL_STEPS - 1)) begin
               step_cnt_in = '0;
               state_in    = ST_DIV;
            end else begin
               step_cnt_in = step_cnt_ff + 1'b1;
            end
         end

         ST_DIV: begin
            for (int i = 0; i < NC; i++) begin
               quot_in[i] = div_sum[i][lfbs_pkg::PROD_W:8];
            end
            state_in = ST_FIX;
         end

         ST_FIX: begin
            for (int i = 0; i < NC; i++) begin
               res_chan_in[i] = quot_ff[i][CW-1:0]
                              + CW'(div_rem[i] >= lfbs_pkg::DIV_CONST);
            end
            res_fading_in = fade_active_ff;
            state_in      = ST_EMIT;
         end

         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_chan_in   = res_chan_ff;
               rsp_fading_in = res_fading_ff;
               state_in      = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      lvl_mplier_ff  <= lvl_mplier_in;
      sq_mcand_ff    <= sq_mcand_in;
      sq_ff          <= sq_in;
      prod_mcand_ff  <= prod_mcand_in;
      chan_mplier_ff <= chan_mplier_in;
      prod_ff        <= prod_in;
      quot_ff        <= quot_in;
      res_chan_ff    <= res_chan_in;
      res_fading_ff  <= res_fading_in;
      rsp_chan_ff    <= rsp_chan_in;
      rsp_fading_ff  <= rsp_fading_in;
      if (reset) begin
         level_max_ff       <= lfbs_pkg::LEVEL_MAX_RESET;
         level_min_ff       <= lfbs_pkg::LEVEL_MIN_RESET;
         level_step_ff      <= lfbs_pkg::STEP_RESET;
         blink_enable_ff    <= 1'b0;
         blink_color_ff     <= '0;
         blink_on_ticks_ff  <= '0;
         blink_off_ticks_ff <= '0;
         fade_active_ff     <= 1'b0;
         rising_ff          <= 1'b1;
         level_ff           <= '0;
         pause_left_ff      <= '0;
         hold_ticks_ff      <= lfbs_pkg::HOLD_DEFAULT;
         fade_color_ff      <= '0;
         blink_on_left_ff   <= '0;
         blink_off_left_ff  <= '0;
         blink_restart_ff   <= 1'b0;
         state_ff           <= ST_IDLE;
         step_cnt_ff        <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         level_max_ff       <= level_max_in;
         level_min_ff       <= level_min_in;
         level_step_ff      <= level_step_in;
         blink_enable_ff    <= blink_enable_in;
         blink_color_ff     <= blink_color_in;
         blink_on_ticks_ff  <= blink_on_ticks_in;
         blink_off_ticks_ff <= blink_off_ticks_in;
         fade_active_ff     <= fade_active_in;
         rising_ff          <= rising_in;
         level_ff           <= level_in;
         pause_left_ff      <= pause_left_in;
         hold_ticks_ff      <= hold_ticks_in;
         fade_color_ff      <= fade_color_in;
         blink_on_left_ff   <= blink_on_left_in;
         blink_off_left_ff  <= blink_off_left_in;
         blink_restart_ff   <= blink_restart_in;
         state_ff           <= state_in;
         step_cnt_ff        <= step_cnt_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   // level is parked at zero whenever no fade runs
   a_level_idle: assert property (@(posedge clock) disable iff (reset)
      !fade_active_ff |-> level_ff == '0)
      else $error("level nonzero with no fade running");

   // a peak hold only happens after the rise has ended
   a_hold_falling: assert property (@(posedge clock) disable iff (reset)
      pause_left_ff != '0 |-> !rising_ff)
      else $error("hold count running while still rising");

   // digit counter only moves inside the two multiply phases
   a_cnt_home: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_SQUARE && state_ff != ST_MULT) |-> step_cnt_ff == '0)
      else $error("digit counter not home outside multiply");

   // quotient estimate is never more than one short
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FIX |-> rem_ok)
      else $error("divide-by-255 remainder out of range");

   // after the multiply, the divide runs ST_DIV, then ST_FIX, then ST_EMIT, with no stall between
   a_fix_to_emit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |=> state_ff == ST_FIX ##1 state_ff == ST_EMIT)
      else $error("divide sequence broken");

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the LED fade/blink sequencer
// Random and directed notify/tick beats are driven with random gaps while the
// result side stalls at random; each tick result is checked against an
// in-bench model of the fade and blink sequencing, across several settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

   localparam logic [lfbs_pkg::KIND_W-1:0]     KIND_SPARE = 2'd3;   // decoded as nothing
   localparam logic [lfbs_pkg::CSR_ADDR_W-1:0] CSR_SPARE  = 3'd7;   // no register here
   localparam int SETTLE_CYCLES = 30;
   localparam int PRESSURE_CYCLES = 250;

   typedef struct packed {
      logic [lfbs_pkg::KIND_W-1:0] kind;
      logic [lfbs_pkg::CHAN_W-1:0] red;
      logic [lfbs_pkg::CHAN_W-1:0] green;
      logic [lfbs_pkg::CHAN_W-1:0] blue;
      logic [lfbs_pkg::HOLD_W-1:0] hold;
   } lamp_cmd_type;

   typedef struct packed {
      logic [lfbs_pkg::CHAN_W-1:0] red;
      logic [lfbs_pkg::CHAN_W-1:0] green;
      logic [lfbs_pkg::CHAN_W-1:0] blue;
      logic                        fading;
   } lamp_px_type;

   typedef struct packed {
      logic [7:0]  level_max;
      logic [7:0]  level_min;
      logic [7:0]  level_step;
      logic        blink_en;
      logic [23:0] blink_color;
      logic [7:0]  on_ticks;
      logic [7:0]  off_ticks;
   } lamp_cfg_type;

   logic                            clock;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic [lfbs_pkg::KIND_W-1:0]     req_kind = '0;
   logic [lfbs_pkg::CHAN_W-1:0]     req_red = '0;
   logic [lfbs_pkg::CHAN_W-1:0]     req_green = '0;
   logic [lfbs_pkg::CHAN_W-1:0]     req_blue = '0;
   logic [lfbs_pkg::HOLD_W-1:0]     req_hold_request = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic [lfbs_pkg::CHAN_W-1:0]     rsp_out_red;
   logic [lfbs_pkg::CHAN_W-1:0]     rsp_out_green;
   logic [lfbs_pkg::CHAN_W-1:0]     rsp_out_blue;
   logic                            rsp_fading;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [lfbs_pkg::CSR_ADDR_W-1:0] csr_index = '0;
   logic [lfbs_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   led_fade_blink_sequencer_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_red          (req_red),
      .req_green        (req_green),
      .req_blue         (req_blue),
      .req_hold_request (req_hold_request),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_red      (rsp_out_red),
      .rsp_out_green    (rsp_out_green),
      .rsp_out_blue     (rsp_out_blue),
      .rsp_fading       (rsp_fading),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // bench copy of the registers
   logic [7:0]  c_level_max   = lfbs_pkg::LEVEL_MAX_RESET;
   logic [7:0]  c_level_min   = lfbs_pkg::LEVEL_MIN_RESET;
   logic [7:0]  c_level_step  = lfbs_pkg::STEP_RESET;
   logic        c_blink_en    = 1'b0;
   logic [23:0] c_blink_color = '0;
   logic [7:0]  c_on_ticks    = '0;
   logic [7:0]  c_off_ticks   = '0;

   // bench copy of the sequencer state
   logic        fd_active   = 1'b0;
   logic        fd_rising   = 1'b1;
   logic [8:0]  fd_level    = '0;
   logic [7:0]  fd_pause    = '0;
   logic [7:0]  fd_hold     = lfbs_pkg::HOLD_DEFAULT;
   logic [23:0] fd_color    = '0;
   logic [7:0]  bl_on_left  = '0;
   logic [7:0]  bl_off_left = '0;
   logic        bl_restart  = 1'b0;

   lamp_cmd_type cmd_backlog[$];
   lamp_px_type  px_expected[$];
   lamp_cmd_type cur_cmd;
   int           cmds_outstanding = 0;
   int           px_seen = 0;
   int           err_count = 0;
   int           req_gap = 0;
   int           rsp_hold = 0;
   bit           req_calm = 1'b0;
   bit           rsp_calm = 1'b0;
   bit           pressure_done = 1'b0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #30_000_000;
      $display("status: fail");
      $finish;
   end

   function automatic int idle_len(bit calm);
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] dim_channel(logic [7:0] c, logic [8:0] lv);
      int unsigned p;
      p = c;
      p = p * lv;
      p = p * lv;
      return 8'(p / 255);
   endfunction

   // advance the sequencer by one accepted beat, queue the tick result if any
   task automatic step_sequencer(lamp_cmd_type c);
      int         ceiling;
      logic [7:0] r, g, b;
      r = '0;
      g = '0;
      b = '0;
      if (c.kind == lfbs_pkg::KIND_NOTIFY || c.kind == lfbs_pkg::KIND_WEAK) begin
         if (!(c.kind == lfbs_pkg::KIND_WEAK && fd_active)) begin
            fd_color  = {c.red, c.green, c.blue};
            fd_rising = 1'b1;
            fd_active = 1'b1;
            fd_level  = {1'b0, c_level_min};
            fd_pause  = '0;
            fd_hold   = (c.hold == '0) ? lfbs_pkg::HOLD_DEFAULT : c.hold;
         end
      end else if (c.kind == lfbs_pkg::KIND_TICK) begin
         if (fd_active) begin
            if (fd_pause == '0) begin
               if (fd_rising) begin
                  // signed compare: ceiling may go negative
                  ceiling = int'(c_level_max) - int'(c_level_step);
                  if (int'(fd_level) >= ceiling) begin
                     fd_rising = 1'b0;
                     fd_pause  = fd_hold;
                  end else begin
                     fd_level = fd_level + c_level_step;
                  end
               end else if (fd_level <= {1'b0, c_level_min} + c_level_step) begin
                  fd_active = 1'b0;
                  fd_level  = '0;
               end else begin
                  fd_level = fd_level - c_level_step;
               end
            end else begin
               fd_pause = fd_pause - 1'b1;
            end
            r = dim_channel(fd_color[23:16], fd_level);
            g = dim_channel(fd_color[15:8], fd_level);
            b = dim_channel(fd_color[7:0], fd_level);
         end else if (c_blink_en) begin
            if (bl_restart) begin
               bl_on_left  = c_on_ticks;
               bl_off_left = '0;
               bl_restart  = 1'b0;
            end
            if (bl_on_left != '0) begin
               bl_on_left = bl_on_left - 1'b1;
               {r, g, b}  = c_blink_color;
            end else if (bl_off_left != '0) begin
               bl_off_left = bl_off_left - 1'b1;
            end else begin
               bl_on_left  = c_on_ticks;
               bl_off_left = c_off_ticks;
            end
         end else begin
            bl_restart  = 1'b1;
            bl_off_left = '0;
         end
         px_expected.push_back(lamp_px_type'{red: r, green: g, blue: b, fading: fd_active});
      end
   endtask

   task automatic flag_mismatch(string what, int got, int want);
      err_count++;
      $display("mismatch %s: got %0d, expected %0d (result beat %0d)",
               what, got, want, px_seen);
   endtask

   // request driver
   always @(posedge clock) begin : drive_req
      logic offer;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if ($urandom_range(0, 63) == 0) req_calm = !req_calm;
         offer = req_valid;
         if (req_valid && !req_stall) begin
            step_sequencer(cur_cmd);
            cmds_outstanding--;
            offer = 1'b0;
         end
         if (!offer) begin
            if (req_gap != 0) begin
               req_gap--;
            end else if (cmd_backlog.size() != 0) begin
               cur_cmd = cmd_backlog.pop_front();
               req_kind         <= cur_cmd.kind;
               req_red          <= cur_cmd.red;
               req_green        <= cur_cmd.green;
               req_blue         <= cur_cmd.blue;
               req_hold_request <= cur_cmd.hold;
               offer   = 1'b1;
               req_gap = idle_len(req_calm);
            end
         end
         req_valid <= offer;
      end
   end

   // result monitor and stall generator
   always @(posedge clock) begin : watch_rsp
      lamp_px_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (px_expected.size() == 0) begin
               flag_mismatch("beat with nothing pending", 1, 0);
            end else begin
               want = px_expected.pop_front();
               if (rsp_out_red !== want.red)
                  flag_mismatch("out_red", rsp_out_red, want.red);
               if (rsp_out_green !== want.green)
                  flag_mismatch("out_green", rsp_out_green, want.green);
               if (rsp_out_blue !== want.blue)
                  flag_mismatch("out_blue", rsp_out_blue, want.blue);
               if (rsp_fading !== want.fading)
                  flag_mismatch("fading", rsp_fading, want.fading);
            end
            px_seen++;
         end
         if ($urandom_range(0, 63) == 0) rsp_calm = !rsp_calm;
         // one long hold-off so the block backs up into the request side
         if (!pressure_done && px_seen >= 40) begin
            pressure_done = 1'b1;
            rsp_hold = PRESSURE_CYCLES;
         end
         if (rsp_hold != 0) begin
            rsp_hold--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            rsp_hold = idle_len(rsp_calm);
         end
      end
   end

   task automatic queue_cmd(lamp_cmd_type c);
      cmd_backlog.push_back(c);
      cmds_outstanding++;
   endtask

   function automatic logic [7:0] pick_chan();
      int r;
      r = $urandom_range(0, 5);
      if (r == 0) return 8'h00;
      if (r == 1) return 8'hff;
      return 8'($urandom);
   endfunction

   function automatic lamp_cmd_type make_cmd(logic [lfbs_pkg::KIND_W-1:0] kind);
      lamp_cmd_type c;
      c.kind  = kind;
      c.red   = pick_chan();
      c.green = pick_chan();
      c.blue  = pick_chan();
      if ($urandom_range(0, 3) == 0)
         c.hold = '0;
      else if ($urandom_range(0, 4) == 0)
         c.hold = 8'($urandom);
      else
         c.hold = 8'($urandom_range(1, 6));
      return c;
   endfunction

   task automatic csr_write(logic [lfbs_pkg::CSR_ADDR_W-1:0] idx,
                            logic [lfbs_pkg::CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         lfbs_pkg::CSR_LEVEL_MAX:       c_level_max   = val[7:0];
         lfbs_pkg::CSR_LEVEL_MIN:       c_level_min   = val[7:0];
         lfbs_pkg::CSR_LEVEL_STEP:      c_level_step  = val[7:0];
         lfbs_pkg::CSR_BLINK_ENABLE:    c_blink_en    = val[0];
         lfbs_pkg::CSR_BLINK_COLOR:     c_blink_color = val[23:0];
         lfbs_pkg::CSR_BLINK_ON_TICKS:  c_on_ticks    = val[7:0];
         lfbs_pkg::CSR_BLINK_OFF_TICKS: c_off_ticks   = val[7:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   // upper bits carry noise to exercise masking of the narrow registers
   task automatic program_lamp(lamp_cfg_type cfg);
      csr_write(lfbs_pkg::CSR_LEVEL_MAX,       {16'($urandom), cfg.level_max});
      csr_write(lfbs_pkg::CSR_LEVEL_MIN,       {16'($urandom), cfg.level_min});
      csr_write(lfbs_pkg::CSR_LEVEL_STEP,      {16'($urandom), cfg.level_step});
      csr_write(lfbs_pkg::CSR_BLINK_ENABLE,    {23'($urandom), cfg.blink_en});
      csr_write(lfbs_pkg::CSR_BLINK_COLOR,     cfg.blink_color);
      csr_write(lfbs_pkg::CSR_BLINK_ON_TICKS,  {16'($urandom), cfg.on_ticks});
      csr_write(lfbs_pkg::CSR_BLINK_OFF_TICKS, {16'($urandom), cfg.off_ticks});
      csr_write(CSR_SPARE,                     24'($urandom));
   endtask

   task automatic drain();
      do @(posedge clock); while (cmds_outstanding != 0 || px_expected.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // mostly notify-then-ticks sequences, with some stray beats mixed in
   task automatic feed_random(int n);
      int made;
      int run;
      made = 0;
      while (made < n) begin
         if ($urandom_range(0, 9) < 8) begin
            queue_cmd(make_cmd(($urandom_range(0, 3) == 0) ? lfbs_pkg::KIND_WEAK
                                                            : lfbs_pkg::KIND_NOTIFY));
            run = ($urandom_range(0, 11) == 0) ? $urandom_range(60, 400)
                                               : $urandom_range(1, 30);
         end else begin
            queue_cmd(make_cmd(2'($urandom_range(0, 3))));
            run = $urandom_range(0, 4);
         end
         if (run > n - made - 1) run = n - made - 1;
         for (int i = 0; i < run; i++) begin
            if ($urandom_range(0, 19) == 0)
               queue_cmd(make_cmd(($urandom_range(0, 1) == 0) ? lfbs_pkg::KIND_WEAK
                                                              : KIND_SPARE));
            queue_cmd(make_cmd(lfbs_pkg::KIND_TICK));
         end
         made += run + 1;
      end
      drain();
   endtask

   task automatic run_phase(lamp_cfg_type cfg, int n);
      program_lamp(cfg);
      feed_random(n);
   endtask

   initial begin : sequence_main
      lamp_cfg_type cfg;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: blink from reset, one full fade at the default levels,
      // weak notify while fading, spare kind, weak notify while idle
      program_lamp('{level_max: 8'd10, level_min: 8'd0, level_step: 8'd2, blink_en: 1'b1,
                     blink_color: 24'hffffff, on_ticks: 8'd2, off_ticks: 8'd1});
      repeat (4) queue_cmd('{lfbs_pkg::KIND_TICK, 8'h00, 8'h00, 8'h00, 8'h00});
      queue_cmd('{lfbs_pkg::KIND_NOTIFY, 8'hff, 8'hff, 8'hff, 8'h00});
      repeat (2) queue_cmd('{lfbs_pkg::KIND_TICK, 8'hff, 8'hff, 8'hff, 8'hff});
      queue_cmd('{lfbs_pkg::KIND_WEAK, 8'h00, 8'h00, 8'h00, 8'h00});
      queue_cmd('{KIND_SPARE, 8'hff, 8'hff, 8'hff, 8'hff});
      repeat (11) queue_cmd('{lfbs_pkg::KIND_TICK, 8'h00, 8'h00, 8'h00, 8'h00});
      queue_cmd('{lfbs_pkg::KIND_WEAK, 8'h80, 8'h40, 8'h01, 8'h01});
      repeat (3) queue_cmd('{lfbs_pkg::KIND_TICK, 8'h55, 8'haa, 8'h55, 8'haa});
      drain();

      run_phase('{8'd10, 8'd0, 8'd2, 1'b1, 24'h123456, 8'd3, 8'd2}, 200);
      // widest fade, blink off
      run_phase('{8'd255, 8'd0, 8'd1, 1'b0, 24'hffffff, 8'd255, 8'd255}, 250);
      // ceiling below step, blink comes back on with zero counts
      run_phase('{8'd1, 8'd255, 8'd255, 1'b1, 24'($urandom), 8'd0, 8'd0}, 200);
      // zero step that still ends
      run_phase('{8'd40, 8'd40, 8'd0, 1'b1, 24'h00ff00, 8'd255, 8'd255}, 150);
      // zero step that never leaves its level
      run_phase('{8'd100, 8'd30, 8'd0, 1'b0, 24'h000000, 8'd1, 8'd1}, 100);
      run_phase('{8'd255, 8'd255, 8'd255, 1'b1, 24'h000000, 8'd1, 8'd0}, 150);
      repeat (3) begin
         cfg.level_max   = 8'($urandom_range(1, 255));
         cfg.level_min   = 8'($urandom_range(0, cfg.level_max));
         cfg.level_step  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                                      : 8'($urandom_range(1, 16));
         cfg.blink_en    = 1'($urandom);
         cfg.blink_color = 24'($urandom);
         cfg.on_ticks    = 8'($urandom_range(0, 6));
         cfg.off_ticks   = 8'($urandom_range(0, 6));
         run_phase(cfg, 150);
      end

      if (err_count == 0 && px_expected.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
